// ===== rtl/bbfa_pkg.sv =====
// Package: types, codes and constants of the bump allocator with best-fit reuse.
package bbfa_pkg;

  localparam int TableDepth = 32;
  localparam int AlignBytes = 8;
  localparam int PageBytes  = 65536;

  localparam logic [32:0] InitMemReset = 33'd65536;
  localparam logic [32:0] MaxMemReset  = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_WRAP     = 3'd2,
    ST_MAX      = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic {
    CFG_INIT_MEM = 1'b0,
    CFG_MAX_MEM  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] size_bytes;
    logic [31:0] address;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pointer;
    logic [31:0] freed_size;
    logic [2:0]  status;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DECIDE,
    S_GROW,
    S_COMMIT,
    S_CLEAR,
    S_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture input beat
    logic scan_start; // reset scan index and results
    logic scan_step;  // examine one entry of both tables
    logic grow;       // compute and apply new memory size
    logic commit;     // write tables and offset, form result
    logic clear;      // clear valid bits and offset
    logic finish;     // form a result with no table change
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic is_reset;
    logic scan_last;
  } stat_t;

endpackage

// ===== rtl/bump_best_fit_allocator.sv =====
// Top level: bump allocator with best-fit reuse of freed chunks.
// One request at a time. An allocate or free is captured, then walks over both
// tables with one entry per cycle, then commits its result; a reset or unused
// mode skips the walk and goes from capture straight to clearing or finishing.
// The result is held until taken, and the next beat is accepted only once the
// controller is back in idle, so a new request cannot begin before the last
// result is taken. Writing initial_memory_bytes has no effect; a hardware reset
// always loads the fixed initial size.
module bump_best_fit_allocator #(
  parameter int TABLE_DEPTH = bbfa_pkg::TableDepth,
  parameter int ALIGN_BYTES = bbfa_pkg::AlignBytes,
  parameter int PAGE_BYTES  = bbfa_pkg::PageBytes
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  bbfa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bbfa_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [32:0]         cfg_data
);

  bbfa_pkg::cmd_t  cmd;
  bbfa_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  bbfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  bbfa_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ALIGN_BYTES (ALIGN_BYTES),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_beat  (in_data),
    .cmd      (cmd),
    .cfg_we   (cfg_valid),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .stat     (stat),
    .result   (out_data)
  );

endmodule

// ===== rtl/bbfa_datapath.sv =====
// Datapath: input capture, tables, scan over entries, growth and result.
module bbfa_datapath #(
  parameter int TABLE_DEPTH = bbfa_pkg::TableDepth,
  parameter int ALIGN_BYTES = bbfa_pkg::AlignBytes,
  parameter int PAGE_BYTES  = bbfa_pkg::PageBytes
) (
  input  logic                clk,
  input  logic                rst,
  input  bbfa_pkg::in_beat_t  in_beat,
  input  bbfa_pkg::cmd_t      cmd,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [32:0]         cfg_data,
  output bbfa_pkg::stat_t     stat,
  output bbfa_pkg::out_beat_t result
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(TABLE_DEPTH - 1);
  localparam logic [33:0] AlignM1 = 34'(ALIGN_BYTES - 1);
  localparam logic [34:0] PageM1  = 35'(PAGE_BYTES - 1);

  logic [32:0] max_mem;
  logic [31:0] bump_offset;
  logic [32:0] memory_bytes;

  logic [TABLE_DEPTH-1:0] live_valid;
  logic [TABLE_DEPTH-1:0] freed_valid;
  logic [31:0] live_addr  [TABLE_DEPTH];
  logic [31:0] live_size  [TABLE_DEPTH];
  logic [31:0] freed_addr [TABLE_DEPTH];
  logic [31:0] freed_size_store [TABLE_DEPTH];

  logic [1:0]  mode;
  logic [31:0] req_size;
  logic [31:0] req_addr;
  logic [33:0] end_addr;

  // scan state
  logic [IW-1:0] idx;
  logic          live_slot_ok;
  logic [IW-1:0] live_slot;
  logic          freed_slot_ok;
  logic [IW-1:0] freed_slot;
  logic          found_ok;
  logic [IW-1:0] found_idx;
  logic          best_ok;
  logic [IW-1:0] best_idx;
  logic [31:0]   best_size;
  logic [31:0]   best_addr;

  logic [33:0] sum_end;
  logic [33:0] start_plus;
  logic [34:0] start_plus4;
  logic [34:0] target;
  logic [34:0] target_pg;
  logic [32:0] target_cap;
  logic [32:0] mem_after;
  logic        grown_fit;

  // commit decision
  logic                do_move;
  logic                do_bump;
  logic                do_reuse;
  logic                do_grow;
  bbfa_pkg::out_beat_t commit_res;

  // Unaligned end of the request
  assign sum_end    = {2'b0, bump_offset} + {2'b0, req_size};
  assign start_plus = sum_end;

  always_comb begin
    start_plus4 = {3'b0, bump_offset} + {1'b0, req_size, 2'b00};
    if (start_plus4 < {2'b0, max_mem}) begin
      target = start_plus4;
    end else begin
      target = {1'b0, start_plus};
    end
    target_pg = ((target + PageM1) / 35'(PAGE_BYTES)) * 35'(PAGE_BYTES);
    if (target_pg > {2'b0, max_mem}) begin
      target_cap = max_mem;
    end else begin
      target_cap = target_pg[32:0];
    end
    if (target_cap > memory_bytes) begin
      mem_after = target_cap;
    end else begin
      mem_after = memory_bytes;
    end
    grown_fit = !(end_addr > {1'b0, mem_after});
  end

  assign stat.is_alloc  = (mode == bbfa_pkg::MODE_ALLOC);
  assign stat.is_free   = (mode == bbfa_pkg::MODE_FREE);
  assign stat.is_reset  = (mode == bbfa_pkg::MODE_RESET);
  assign stat.scan_last = (idx == LastIdx);

  // Configuration register: only the maximum size is stored; initial size writes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      max_mem <= bbfa_pkg::MaxMemReset;
    end else if (cfg_we && cfg_idx == bbfa_pkg::CFG_MAX_MEM) begin
      max_mem <= cfg_data;
    end
  end

  // Capture the beat and its aligned end
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= in_beat.mode;
      req_size <= in_beat.size_bytes;
      req_addr <= in_beat.address;
    end
    if (cmd.scan_start) begin
      end_addr <= ((sum_end + AlignM1) / 34'(ALIGN_BYTES)) * 34'(ALIGN_BYTES);
    end
  end

  // Walk one entry per cycle: free slots, lookup, best fit
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx           <= '0;
      live_slot_ok  <= 1'b0;
      freed_slot_ok <= 1'b0;
      found_ok      <= 1'b0;
      best_ok       <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!stat.scan_last) begin
        idx <= idx + 1'b1;
      end
      if (!live_valid[idx] && !live_slot_ok) begin
        live_slot_ok <= 1'b1;
        live_slot    <= idx;
      end
      if (!freed_valid[idx] && !freed_slot_ok) begin
        freed_slot_ok <= 1'b1;
        freed_slot    <= idx;
      end
      if (live_valid[idx] && live_addr[idx] == req_addr && !found_ok) begin
        found_ok  <= 1'b1;
        found_idx <= idx;
      end
      if (freed_valid[idx] && !(freed_size_store[idx] < req_size) &&
          (!best_ok || freed_size_store[idx] < best_size ||
           (freed_size_store[idx] == best_size && freed_addr[idx] < best_addr))) begin
        best_ok   <= 1'b1;
        best_idx  <= idx;
        best_size <= freed_size_store[idx];
        best_addr <= freed_addr[idx];
      end
    end
  end

  // Decide the outcome of the request once the scan is done
  always_comb begin
    do_move    = 1'b0;
    do_bump    = 1'b0;
    do_reuse   = 1'b0;
    do_grow    = 1'b0;
    commit_res = '{pointer: '0, freed_size: '0, status: bbfa_pkg::ST_OK};
    if (stat.is_free) begin
      if (!found_ok) begin
        commit_res.status = bbfa_pkg::ST_NOTFOUND;
      end else if (!freed_slot_ok) begin
        commit_res.status = bbfa_pkg::ST_FULL;
      end else begin
        do_move               = 1'b1;
        commit_res.freed_size = live_size[found_idx];
      end
    end else if (req_size == '0) begin
      commit_res.status = bbfa_pkg::ST_ZERO;
    end else if (end_addr[33:32] != 2'b00) begin
      commit_res.status = bbfa_pkg::ST_WRAP;
    end else if (!live_slot_ok) begin
      commit_res.status = bbfa_pkg::ST_FULL;
    end else if (!(end_addr > {1'b0, memory_bytes})) begin
      do_bump            = 1'b1;
      commit_res.pointer = bump_offset;
    end else if (best_ok) begin
      do_reuse           = 1'b1;
      commit_res.pointer = best_addr;
    end else if (start_plus > {1'b0, max_mem}) begin
      commit_res.status = bbfa_pkg::ST_MAX;
    end else begin
      do_grow = 1'b1;
      if (grown_fit) begin
        do_bump            = 1'b1;
        commit_res.pointer = bump_offset;
      end else begin
        commit_res.status = bbfa_pkg::ST_MAX;
      end
    end
  end

  // Tables, offset, memory size and result
  always_ff @(posedge clk) begin
    if (rst) begin
      live_valid   <= '0;
      freed_valid  <= '0;
      bump_offset  <= 32'd1;
      memory_bytes <= bbfa_pkg::InitMemReset;
    end else begin
      if (cmd.clear) begin
        live_valid  <= '0;
        freed_valid <= '0;
        bump_offset <= 32'd1;
        result      <= '{pointer: '0, freed_size: '0, status: bbfa_pkg::ST_OK};
      end
      if (cmd.finish) begin
        result <= '{pointer: '0, freed_size: '0, status: bbfa_pkg::ST_OK};
      end
      if (cmd.grow) begin
        memory_bytes <= mem_after;
      end
      if (cmd.commit) begin
        result <= commit_res;
        if (do_move) begin
          freed_valid[freed_slot]      <= 1'b1;
          freed_addr[freed_slot]       <= req_addr;
          freed_size_store[freed_slot] <= live_size[found_idx];
          live_valid[found_idx]        <= 1'b0;
        end
        if (do_reuse) begin
          live_valid[live_slot] <= 1'b1;
          live_addr[live_slot]  <= best_addr;
          live_size[live_slot]  <= best_size;
          freed_valid[best_idx] <= 1'b0;
        end
        if (do_grow) begin
          memory_bytes <= mem_after;
        end
        if (do_bump) begin
          live_valid[live_slot] <= 1'b1;
          live_addr[live_slot]  <= bump_offset;
          live_size[live_slot]  <= req_size;
          bump_offset           <= end_addr[31:0];
        end
      end
    end
  end

endmodule

// ===== rtl/bbfa_ctrl.sv =====
// Controller: sequences capture, table scan, commit and result handshake.
module bbfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  bbfa_pkg::stat_t stat,
  output bbfa_pkg::cmd_t  cmd
);

  bbfa_pkg::state_t state;
  bbfa_pkg::state_t state_next;
  logic             in_take;

  assign in_take = (state == bbfa_pkg::S_IDLE) && in_valid;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbfa_pkg::S_IDLE:   if (in_valid) state_next = bbfa_pkg::S_CHECK;
      bbfa_pkg::S_CHECK: begin
        if (stat.is_reset) begin
          state_next = bbfa_pkg::S_CLEAR;
        end else if (stat.is_alloc || stat.is_free) begin
          state_next = bbfa_pkg::S_SCAN;
        end else begin
          state_next = bbfa_pkg::S_DECIDE;
        end
      end
      bbfa_pkg::S_SCAN:   if (stat.scan_last) state_next = bbfa_pkg::S_COMMIT;
      bbfa_pkg::S_DECIDE: state_next = bbfa_pkg::S_DONE;
      bbfa_pkg::S_GROW:   state_next = bbfa_pkg::S_DONE;
      bbfa_pkg::S_COMMIT: state_next = bbfa_pkg::S_DONE;
      bbfa_pkg::S_CLEAR:  state_next = bbfa_pkg::S_DONE;
      bbfa_pkg::S_DONE:   if (!out_stall) state_next = bbfa_pkg::S_IDLE;
      default:            state_next = bbfa_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd            = '0;
    cmd.load       = in_take;
    cmd.scan_start = (state == bbfa_pkg::S_CHECK);
    cmd.scan_step  = (state == bbfa_pkg::S_SCAN);
    cmd.commit     = (state == bbfa_pkg::S_COMMIT);
    cmd.clear      = (state == bbfa_pkg::S_CLEAR);
    cmd.finish     = (state == bbfa_pkg::S_DECIDE);
    cmd.grow       = 1'b0;
    in_stall       = (state != bbfa_pkg::S_IDLE);
    out_valid      = (state == bbfa_pkg::S_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbfa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
